// ===== rtl/kdmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kdmp_pkg;

  localparam int KEYS_DEFAULT         = 12;
  localparam int QUEUE_DEPTH_DEFAULT  = 16;
  localparam int MACRO_LENGTH_DEFAULT = 6;

  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic CFG_TRIGGER_KEY  = 1'b0;
  localparam logic CFG_STABLE_SCANS = 1'b1;

  localparam logic [2:0] STABLE_SCANS_RESET = 3'd5;

  // hid modifier bits and usage codes
  localparam logic [7:0] MOD_CTRL_SHIFT = 8'h03;
  localparam logic [7:0] USAGE_U        = 8'h18;
  localparam logic [7:0] USAGE_0        = 8'h27;
  localparam logic [7:0] USAGE_3        = 8'h20;
  localparam logic [7:0] USAGE_B        = 8'h05;
  localparam logic [7:0] USAGE_ENTER    = 8'h28;

  typedef struct packed {
    logic       opcode;
    logic [3:0] key_num;
    logic       key_pressed;
    logic       host_ready;
    logic       report_taken;
  } in_item_t;

  typedef struct packed {
    logic       report_valid;
    logic [7:0] report_modifier;
    logic [7:0] report_keycode;
    logic       macro_busy;
  } out_item_t;

  typedef struct packed {
    logic [3:0] trigger_key;
    logic [2:0] stable_scans;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_SKIP,
    CMD_SAMPLE,
    CMD_POLL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [3:0] key;
    logic       level;
    logic       taken;
  } cmd_t;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] keycode;
  } chord_t;

  function automatic chord_t chord_lookup(input logic [2:0] step);
    chord_t c;
    c = '0;
    case (step)
      3'd0: begin
        c.modifier = MOD_CTRL_SHIFT;
        c.keycode  = USAGE_U;
      end
      3'd1: c.keycode = USAGE_0;
      3'd2: c.keycode = USAGE_3;
      3'd3: c.keycode = USAGE_B;
      3'd4: c.keycode = USAGE_B;
      3'd5: c.keycode = USAGE_ENTER;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kdmp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdmp_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kdmp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdmp_front #(
  parameter int KEYS = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire kdmp_pkg::in_item_t item_i,
  input  wire logic              cmd_pop_i,
  output logic                   cmd_empty_o,
  output kdmp_pkg::cmd_t         cmd_o
);

  import kdmp_pkg::*;

  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  // out-of-range samples and polls without a ready host become skip commands, which touch no key or sequencer state
  always_comb begin
    cmd_in       = '0;
    cmd_in.key   = item_i.key_num;
    cmd_in.level = item_i.key_pressed;
    cmd_in.taken = item_i.report_taken;
    if (item_i.opcode) begin
      cmd_in.kind = item_i.host_ready ? CMD_POLL : CMD_SKIP;
    end else begin
      cmd_in.kind = (int'(item_i.key_num) < KEYS) ? CMD_SAMPLE : CMD_SKIP;
    end
  end

  kdmp_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty_o),
    .rdata_o (cmd_bits)
  );

  assign cmd_o = cmd_t'(cmd_bits);

endmodule

`default_nettype wire

// ===== rtl/kdmp_debounce.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdmp_debounce #(
  parameter int KEYS = 12
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           sample_i,
  input  wire logic [3:0]     key_i,
  input  wire logic           level_i,
  input  wire kdmp_pkg::cfg_t cfg_i,
  output logic                press_o
);

  import kdmp_pkg::*;

  // the key number is four bits wide, so at most sixteen keys are reachable
  localparam int KEY_SLOTS = (KEYS < 16) ? KEYS : 16;
  localparam int KIW       = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [KEY_SLOTS-1:0] raw_last_q;
  logic [KEY_SLOTS-1:0] stable_level_q;
  logic [2:0]           stable_count_q [KEY_SLOTS];

  logic [KIW-1:0] idx;
  logic           raw_nxt;
  logic [2:0]     count_nxt;
  logic           flip;

  assign idx = key_i[KIW-1:0];

  always_comb begin
    raw_nxt   = raw_last_q[idx];
    count_nxt = stable_count_q[idx];
    if (level_i != raw_last_q[idx]) begin
      raw_nxt   = level_i;
      count_nxt = 3'd1;
    end else if (stable_count_q[idx] < cfg_i.stable_scans) begin
      count_nxt = stable_count_q[idx] + 3'd1;
    end
    flip    = !(count_nxt < cfg_i.stable_scans) && (stable_level_q[idx] != level_i);
    press_o = sample_i && flip && level_i && (key_i == cfg_i.trigger_key);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q     <= '0;
      stable_level_q <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        stable_count_q[i] <= 3'd0;
      end
    end else if (sample_i) begin
      raw_last_q[idx]     <= raw_nxt;
      stable_count_q[idx] <= count_nxt;
      if (flip) begin
        stable_level_q[idx] <= level_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kdmp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdmp_seq #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int MACRO_LENGTH = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          press_i,
  input  wire logic          poll_i,
  input  wire logic          taken_i,
  output kdmp_pkg::out_item_t result_o
);

  import kdmp_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int SW = (MACRO_LENGTH > 1) ? $clog2(MACRO_LENGTH) : 1;

  // every queued entry is a macro request, so only the ring pointers are kept
  logic [QW-1:0] wr_q, wr_d, wr_next;
  logic [QW-1:0] rd_q, rd_d, rd_next;
  logic          playing_q, playing_d;
  logic [SW-1:0] step_q, step_d;
  logic [SW:0]   step_inc;
  logic          await_q, await_d;
  logic          go;
  chord_t        chord;

  assign wr_next  = (wr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign rd_next  = (rd_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
  assign step_inc = {1'b0, step_q} + 1'b1;

  always_comb begin
    wr_d      = wr_q;
    rd_d      = rd_q;
    playing_d = playing_q;
    step_d    = step_q;
    await_d   = await_q;
    go        = playing_q;
    result_o  = '0;
    chord     = '0;

    // one slot stays free, a press into a full ring is dropped
    if (press_i && (wr_next != rd_q)) begin
      wr_d = wr_next;
    end

    if (poll_i) begin
      if (!playing_q && (wr_q != rd_q)) begin
        rd_d      = rd_next;
        playing_d = 1'b1;
        step_d    = '0;
        await_d   = 1'b0;
        go        = 1'b1;
      end
      if (go) begin
        result_o.report_valid = 1'b1;
        if (!await_d) begin
          chord                    = chord_lookup(3'(step_d));
          result_o.report_modifier = chord.modifier;
          result_o.report_keycode  = chord.keycode;
          if (taken_i) begin
            await_d = 1'b1;
          end
        end else if (taken_i) begin
          await_d = 1'b0;
          if (step_inc >= (SW + 1)'(MACRO_LENGTH)) begin
            playing_d = 1'b0;
            step_d    = '0;
          end else begin
            step_d = step_inc[SW-1:0];
          end
        end
      end
    end
    result_o.macro_busy = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      playing_q <= 1'b0;
      step_q    <= '0;
      await_q   <= 1'b0;
    end else begin
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      playing_q <= playing_d;
      step_q    <= step_d;
      await_q   <= await_d;
    end
  end

  a_release_only_while_playing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) await_q |-> playing_q
  ) else $error("release pending with no macro playing");

  a_idle_step_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !playing_q |-> (step_q == '0)
  ) else $error("chord step left nonzero after macro end");

  a_ptrs_in_ring : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (int'(wr_q) < QUEUE_DEPTH) && (int'(rd_q) < QUEUE_DEPTH)
  ) else $error("request ring pointer out of range");

  a_start_needs_request : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (poll_i && !playing_q && (wr_q == rd_q)) |-> !result_o.report_valid
  ) else $error("report offered with no request queued");

endmodule

`default_nettype wire

// ===== rtl/key_debounce_macro_player_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+--------------------------
// items     | in        | push / full           | in_item_i  (in_item_t)
// results   | out       | empty / pop           | out_item_o (out_item_t)
// config    | in        | cfg_we_i, cfg_idx_i   | cfg_data_i
//
// one item per cycle sustained while no stall backs up from the result side; an item passes
// through the command queue, then the debounce/sequencer logic writes the result queue
// exactly one result per item, in order
// reset clears key state, ring pointers, sequencer and queues; no clearing pass
// a stall on the result side backs up through the result and command queues

module key_debounce_macro_player_unit #(
  parameter int KEYS         = kdmp_pkg::KEYS_DEFAULT,
  parameter int QUEUE_DEPTH  = kdmp_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int MACRO_LENGTH = kdmp_pkg::MACRO_LENGTH_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire kdmp_pkg::in_item_t              in_item_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output kdmp_pkg::out_item_t                  out_item_o,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [kdmp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import kdmp_pkg::*;

  cfg_t      cfg_q;
  cmd_t      cmd;
  logic      cmd_empty;
  logic      res_full;
  logic      fire;
  logic      press;
  out_item_t result;
  logic [$bits(out_item_t)-1:0] res_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_key  <= 4'd0;
      cfg_q.stable_scans <= STABLE_SCANS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIGGER_KEY:  cfg_q.trigger_key  <= cfg_data_i[3:0];
        CFG_STABLE_SCANS: cfg_q.stable_scans <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  kdmp_front #(
    .KEYS (KEYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .cmd_pop_i   (fire),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  // back stage retires one command whenever one is queued and the result queue has room
  assign fire = !cmd_empty && !res_full;

  kdmp_debounce #(
    .KEYS (KEYS)
  ) u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (fire && (cmd.kind == CMD_SAMPLE)),
    .key_i    (cmd.key),
    .level_i  (cmd.level),
    .cfg_i    (cfg_q),
    .press_o  (press)
  );

  kdmp_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MACRO_LENGTH (MACRO_LENGTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .press_i  (press),
    .poll_i   (fire && (cmd.kind == CMD_POLL)),
    .taken_i  (cmd.taken),
    .result_o (result)
  );

  kdmp_fifo #(
    .WIDTH ($bits(out_item_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .full_o  (res_full),
    .wdata_i (result),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_bits)
  );

  assign out_item_o = out_item_t'(res_bits);

endmodule

`default_nettype wire
